[sv/fddf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fddf_pkg
// Shared types, register indexes and stencil coefficient tables of the
// streaming finite-difference derivative filter.
// ---------------------------------------------------------------------------
package fddf_pkg;

   localparam int STENCIL_TAPS = 7;
   localparam int COEF_W       = 12;
   localparam int FRAC_BITS    = 16;
   localparam int ROW_OUT_W    = 12;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int LEN_REG_W    = 13;
   localparam int MIN_LINE     = 8;
   localparam int RESULT_W     = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORDER_MODE        = 2'd0,
      CSR_SECOND_DERIVATIVE = 2'd1,
      CSR_LINE_LENGTH       = 2'd2,
      CSR_SCALE             = 2'd3
   } csr_index_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   // per-result bookkeeping carried alongside the datapath
   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic                 last;
   } meta_type;

   // stencils over offsets -3..+3, scaled by 180
   // rows: left edge, right edge, central 2nd, central 4th, central 6th
   localparam coef_type FIRST_TAB [5][STENCIL_TAPS] = '{
      '{ 12'sd0,    12'sd0,    12'sd0,    -12'sd180, 12'sd180,  12'sd0,    12'sd0 },
      '{ 12'sd0,    12'sd0,    -12'sd180, 12'sd180,  12'sd0,    12'sd0,    12'sd0 },
      '{ 12'sd0,    12'sd0,    -12'sd90,  12'sd0,    12'sd90,   12'sd0,    12'sd0 },
      '{ 12'sd0,    12'sd15,   -12'sd120, 12'sd0,    12'sd120,  -12'sd15,  12'sd0 },
      '{ -12'sd3,   12'sd27,   -12'sd135, 12'sd0,    12'sd135,  -12'sd27,  12'sd3 }
   };

   localparam coef_type SECOND_TAB [5][STENCIL_TAPS] = '{
      '{ 12'sd0,    12'sd0,    12'sd0,    12'sd360,  -12'sd900, 12'sd720,  -12'sd180 },
      '{ -12'sd180, 12'sd720,  -12'sd900, 12'sd360,  12'sd0,    12'sd0,    12'sd0 },
      '{ 12'sd0,    12'sd0,    12'sd180,  -12'sd360, 12'sd180,  12'sd0,    12'sd0 },
      '{ 12'sd0,    -12'sd15,  12'sd240,  -12'sd450, 12'sd240,  -12'sd15,  12'sd0 },
      '{ 12'sd2,    -12'sd27,  12'sd270,  -12'sd490, 12'sd270,  -12'sd27,  12'sd2 }
   };

   function automatic coef_type stencil_coef(input logic sec, input logic [2:0] t,
                                             input logic [2:0] j);
      coef_type c;
      c = sec ? SECOND_TAB[t][j] : FIRST_TAB[t][j];
      return c;
   endfunction

endpackage

[sv/finite_difference_derivative_filter_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// finite_difference_derivative_filter_unit
// Streams one grid line of samples through a seven-tap first or second
// derivative stencil (2nd, 4th or 6th order, with edge stencils) and scales
// the integer sum by a Q16.16 factor with floor and 32-bit saturation.
// ---------------------------------------------------------------------------
// Takes one sample per clock cycle while req_ready is high. Each sample at
// position p >= 3 gives the result for row p-3; the final sample of a line
// also gives rows len-3 to len-1, so after it req_ready stays low while the
// three flush rows are issued from the same stencil window. A result passes
// through the window/issue register, tap products, stencil sum, scale
// product, then saturation into the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so a stall
// at rsp_ready holds every stage. line_length is clamped to [8, MAX_LINE];
// configuration must be written only while the unit is idle; the unit
// itself does not enforce this.
// ---------------------------------------------------------------------------
module finite_difference_derivative_filter_unit #(
   parameter int MAX_LINE     = 4096,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [fddf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fddf_pkg::CSR_DATA_W-1:0]      csr_write_data,
   // sample stream
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   // derivative stream
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [fddf_pkg::RESULT_W-1:0] rsp_derivative,
   output logic [fddf_pkg::ROW_OUT_W-1:0]       rsp_row,
   output logic                                 rsp_last_of_line
);

   import fddf_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int RW    = $clog2(MAX_LINE);
   localparam int LW    = $clog2(MAX_LINE + 1);
   localparam int CW    = (LW > LEN_REG_W) ? LW : LEN_REG_W;
   localparam int PW    = SW + COEF_W;
   localparam int SUMW  = PW + 3;
   localparam int MULW  = SUMW + CSR_DATA_W + 1;
   localparam int SHW   = MULW - FRAC_BITS;

   localparam logic [CW-1:0] LEN_MAX_C = CW'(MAX_LINE);
   localparam logic [CW-1:0] LEN_MIN_C = CW'(MIN_LINE);
   localparam logic signed [SHW-1:0] SAT_HI = {{(SHW-RESULT_W+1){1'b0}}, {(RESULT_W-1){1'b1}}};
   localparam logic signed [SHW-1:0] SAT_LO = {{(SHW-RESULT_W+1){1'b1}}, {(RESULT_W-1){1'b0}}};

   // configuration registers
   logic [1:0]            order_mode_ff;
   logic                  second_ff;
   logic [LEN_REG_W-1:0]  line_length_ff;
   logic [CSR_DATA_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff  <= 2'd0;
         second_ff      <= 1'b0;
         line_length_ff <= LEN_REG_W'(64);
         scale_ff       <= CSR_DATA_W'(65536);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ORDER_MODE:        order_mode_ff  <= csr_write_data[1:0];
            CSR_SECOND_DERIVATIVE: second_ff      <= csr_write_data[0];
            CSR_LINE_LENGTH:       line_length_ff <= csr_write_data[LEN_REG_W-1:0];
            CSR_SCALE:             scale_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective line length and derived values
   logic [CW-1:0] len_raw;
   logic [CW-1:0] len_clamped;
   logic [LW-1:0] eff_len;
   logic [LW-1:0] len_m1;
   logic [1:0]    order_eff;

   always_comb begin
      len_raw = CW'(line_length_ff);
      if (len_raw < LEN_MIN_C)      len_clamped = LEN_MIN_C;
      else if (len_raw > LEN_MAX_C) len_clamped = LEN_MAX_C;
      else                          len_clamped = len_raw;
      eff_len   = LW'(len_clamped);
      len_m1    = eff_len - LW'(1);
      order_eff = (order_mode_ff == 2'd3) ? 2'd2 : order_mode_ff;
   end

   // pipeline advance: output register empty or being taken
   logic rsp_valid_ff;
   logic adv;
   logic accept;
   logic [1:0] flush_cnt_ff, flush_cnt_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && (flush_cnt_ff == 2'd0);
   assign accept    = req_valid && req_ready;

   // stage A: window and issue registers
   logic signed [SW-1:0] window_ff [STENCIL_TAPS];
   logic [RW-1:0]        pos_ff, pos_in;
   logic                 a_valid_ff, a_valid_in;
   logic [RW-1:0]        a_row_ff, a_row_in;
   logic [1:0]           a_delta_ff, a_delta_in;
   logic [RW-1:0]        p_cur;
   logic                 p_last;

   always_comb begin
      p_cur        = (LW'(pos_ff) >= eff_len) ? RW'(0) : pos_ff;
      p_last       = (LW'(p_cur) == len_m1);
      pos_in       = pos_ff;
      flush_cnt_in = flush_cnt_ff;
      a_valid_in   = a_valid_ff;
      a_row_in     = a_row_ff;
      a_delta_in   = a_delta_ff;
      if (adv) begin
         if (flush_cnt_ff != 2'd0) begin
            // flush rows reuse the window left by the final sample
            a_valid_in   = 1'b1;
            a_row_in     = a_row_ff + RW'(1);
            a_delta_in   = a_delta_ff - 2'd1;
            flush_cnt_in = flush_cnt_ff - 2'd1;
         end else if (accept) begin
            a_valid_in   = (p_cur >= RW'(3));
            a_row_in     = p_cur - RW'(3);
            a_delta_in   = 2'd3;
            flush_cnt_in = p_last ? 2'd3 : 2'd0;
            pos_in       = p_last ? RW'(0) : p_cur + RW'(1);
         end else begin
            a_valid_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         flush_cnt_ff <= 2'd0;
         a_valid_ff   <= 1'b0;
         for (int i = 0; i < STENCIL_TAPS; i++) window_ff[i] <= '0;
      end else begin
         pos_ff       <= pos_in;
         flush_cnt_ff <= flush_cnt_in;
         a_valid_ff   <= a_valid_in;
         if (accept) begin
            for (int i = 0; i < STENCIL_TAPS - 1; i++) window_ff[i] <= window_ff[i+1];
            window_ff[STENCIL_TAPS-1] <= req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_row_ff   <= a_row_in;
      a_delta_ff <= a_delta_in;
   end

   // stage B: stencil selection and tap products
   logic [LW-1:0]        row_l;
   logic [LW-1:0]        dist_end;
   logic [LW-1:0]        dist_edge;
   logic [2:0]           tab_sel;
   meta_type             b_meta_in;
   logic signed [PW-1:0] b_prod_in [STENCIL_TAPS];
   logic [RW+1:0]        col_off;
   logic [2:0]           win_idx;
   logic                 tap_used;
   coef_type             tap_coef;

   always_comb begin
      row_l     = LW'(a_row_ff);
      dist_end  = len_m1 - row_l;
      dist_edge = (row_l < dist_end) ? row_l : dist_end;
      if (dist_edge >= LW'(order_eff) + LW'(1)) tab_sel = 3'(order_eff) + 3'd2;
      else if (dist_edge == LW'(0))              tab_sel = (row_l == LW'(0)) ? 3'd0 : 3'd1;
      else                                       tab_sel = 3'(dist_edge) + 3'd1;

      b_meta_in.row  = ROW_OUT_W'(a_row_ff);
      b_meta_in.last = (row_l == len_m1);

      col_off  = '0;
      win_idx  = '0;
      tap_used = 1'b0;
      tap_coef = '0;
      for (int j = 0; j < STENCIL_TAPS; j++) begin
         // tap j covers column row+j-3; columns outside the line drop out
         col_off  = (RW+2)'(a_row_ff) + (RW+2)'(j);
         win_idx  = 3'(j) + 3'd3 - 3'(a_delta_ff);
         tap_used = (col_off >= (RW+2)'(3)) && (col_off < (RW+2)'(eff_len) + (RW+2)'(3))
                    && (3'(j) <= 3'd3 + 3'(a_delta_ff));
         tap_coef = stencil_coef(second_ff, tab_sel, 3'(j));
         b_prod_in[j] = tap_used ? PW'(window_ff[win_idx] * tap_coef) : '0;
      end
   end

   logic                 b_valid_ff;
   meta_type             b_meta_ff;
   logic signed [PW-1:0] b_prod_ff [STENCIL_TAPS];

   // stage C: stencil sum
   logic signed [SUMW-1:0] c_sum_in;

   always_comb begin
      c_sum_in = '0;
      for (int j = 0; j < STENCIL_TAPS; j++) c_sum_in = c_sum_in + SUMW'(b_prod_ff[j]);
   end

   logic                   c_valid_ff;
   meta_type               c_meta_ff;
   logic signed [SUMW-1:0] c_sum_ff;

   // stage D: scale product
   logic signed [MULW-1:0] d_prod_in;
   assign d_prod_in = MULW'(c_sum_ff * $signed({1'b0, scale_ff}));

   logic                   d_valid_ff;
   meta_type               d_meta_ff;
   logic signed [MULW-1:0] d_prod_ff;

   // stage E: floor shift and saturation
   logic signed [SHW-1:0]      shifted;
   logic signed [RESULT_W-1:0] deriv_in;

   always_comb begin
      shifted = SHW'(d_prod_ff >>> FRAC_BITS);
      if (shifted > SAT_HI)      deriv_in = SAT_HI[RESULT_W-1:0];
      else if (shifted < SAT_LO) deriv_in = SAT_LO[RESULT_W-1:0];
      else                       deriv_in = shifted[RESULT_W-1:0];
   end

   logic signed [RESULT_W-1:0] rsp_derivative_ff;
   logic [ROW_OUT_W-1:0]       rsp_row_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_meta_ff <= b_meta_in;
         for (int j = 0; j < STENCIL_TAPS; j++) b_prod_ff[j] <= b_prod_in[j];
         c_meta_ff <= b_meta_ff;
         c_sum_ff  <= c_sum_in;
         d_meta_ff <= c_meta_ff;
         d_prod_ff <= d_prod_in;
         rsp_derivative_ff <= deriv_in;
         rsp_row_ff        <= d_meta_ff.row;
         rsp_last_ff       <= d_meta_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_derivative   = rsp_derivative_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_last_of_line = rsp_last_ff;

   // during a flush the issue stage always holds a row
   assert property (@(posedge clock) disable iff (reset)
      (flush_cnt_ff != 2'd0) |-> a_valid_ff)
      else $error("flush in progress without an issued row");

   // remaining flush rows track the row offset from the newest sample
   assert property (@(posedge clock) disable iff (reset)
      (flush_cnt_ff != 2'd0) |-> (a_delta_ff == flush_cnt_ff))
      else $error("flush row offset out of step with flush count");

   // a transfer that wraps the position must start the three-row flush
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (pos_ff != '0) || (flush_cnt_ff == 2'd3))
      else $error("line wrapped without flushing the final rows");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming finite-difference derivative filter.
// ---------------------------------------------------------------------------
// Streams sample lines into the unit under several register settings (all
// orders, both operators, clamped and extreme line lengths, zero and full
// scale) with random idling on both streams. A tracker class keeps its own
// sample window and line position, predicts every derivative transfer and
// compares each one field by field as it leaves the unit.
// ---------------------------------------------------------------------------
module tb_top;
   import fddf_pkg::*;

   localparam int LIMIT_CYCLES = 250000;
   localparam int SETTLE       = 10;
   localparam int RANDOM_ITEMS = 72;

   class derivative_tracker;
      typedef struct {
         logic signed [31:0] value;
         logic [11:0]        row;
         logic               last;
      } deriv_type;

      deriv_type pending_derivs[$];
      // taps over offsets -3..+3, times 180
      // left edge, right edge, central 2nd, central 4th, central 6th
      int slope_taps[5][7] = '{
         '{0, 0, 0, -180, 180, 0, 0},
         '{0, 0, -180, 180, 0, 0, 0},
         '{0, 0, -90, 0, 90, 0, 0},
         '{0, 15, -120, 0, 120, -15, 0},
         '{-3, 27, -135, 0, 135, -27, 3}
      };
      int curve_taps[5][7] = '{
         '{0, 0, 0, 360, -900, 720, -180},
         '{-180, 720, -900, 360, 0, 0, 0},
         '{0, 0, 180, -360, 180, 0, 0},
         '{0, -15, 240, -450, 240, -15, 0},
         '{2, -27, 270, -490, 270, -27, 2}
      };
      logic [1:0]         order_mode;
      logic               second_deriv;
      logic [12:0]        line_len;
      logic [31:0]        scale;
      logic signed [15:0] window[7];
      int                 position;
      int                 mismatches;
      int                 checked;

      function new();
         order_mode   = 2'd0;
         second_deriv = 1'b0;
         line_len     = 13'd64;
         scale        = 32'd65536;
         foreach (window[i]) window[i] = '0;
         position   = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void configure(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_ORDER_MODE:        order_mode   = data[1:0];
            CSR_SECOND_DERIVATIVE: second_deriv = data[0];
            CSR_LINE_LENGTH:       line_len     = data[12:0];
            CSR_SCALE:             scale        = data;
            default: ;
         endcase
      endfunction

      function int eff_len();
         int l;
         l = line_len;
         if (l < 8) l = 8;
         if (l > 4096) l = 4096;
         return l;
      endfunction

      // floor of sum * scale / 2^16, saturated to 32 bit
      function logic signed [31:0] scaled(longint sum);
         logic signed [63:0] prod;
         prod = sum * longint'({32'd0, scale});
         prod = prod >>> 16;
         if (prod > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (prod < -64'sd2147483648) return 32'sh8000_0000;
         return prod[31:0];
      endfunction

      function logic signed [31:0] stencil_value(int r, int p, int len);
         int     m, e, b, t, c, idx, k;
         longint sum;
         m = (order_mode > 2) ? 2 : int'(order_mode);
         e = len - 1 - r;
         b = (r < e) ? r : e;
         if (b >= m + 1) t = 2 + m;
         else if (b == 0) t = (r == 0) ? 0 : 1;
         else t = b + 1;
         sum = 0;
         for (int d = -3; d <= 3; d++) begin
            c   = r + d;
            idx = c - p + 6;
            // columns off the line weigh nothing, so stale samples drop out
            if (c >= 0 && c < len && idx >= 0 && idx <= 6) begin
               k = second_deriv ? curve_taps[t][d + 3] : slope_taps[t][d + 3];
               sum += longint'(k) * longint'(window[idx]);
            end
         end
         return scaled(sum);
      endfunction

      function void push_row(int r, int p, int len);
         deriv_type x;
         x.value = stencil_value(r, p, len);
         x.row   = r[11:0];
         x.last  = (r == len - 1);
         pending_derivs.push_back(x);
      endfunction

      function void note_sample(logic signed [15:0] s);
         int len, p;
         len = eff_len();
         // a shortened line restarts at zero
         if (position >= len) position = 0;
         for (int i = 0; i < 6; i++) window[i] = window[i + 1];
         window[6] = s;
         p = position;
         if (p >= 3) push_row(p - 3, p, len);
         if (p == len - 1) begin
            push_row(p - 2, p, len);
            push_row(p - 1, p, len);
            push_row(p, p, len);
            position = 0;
         end else begin
            position = p + 1;
         end
      endfunction

      function void check_derivative(logic signed [31:0] v, logic [11:0] row, logic last);
         deriv_type x;
         checked++;
         if (pending_derivs.size() == 0) begin
            $error("unexpected derivative transfer: row %0d value %0d", row, v);
            mismatches++;
            return;
         end
         x = pending_derivs.pop_front();
         if (v !== x.value) begin
            $error("derivative: expected %0d, actual %0d", x.value, v);
            mismatches++;
         end
         if (row !== x.row) begin
            $error("row: expected %0d, actual %0d", x.row, row);
            mismatches++;
         end
         if (last !== x.last) begin
            $error("last_of_line: expected %0b, actual %0b", x.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [15:0]   req_sample;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [31:0]   rsp_derivative;
   logic [11:0]          rsp_row;
   logic                 rsp_last_of_line;

   derivative_tracker    tracker;
   bit                   steady = 1'b0;
   int                   cycles = 0;
   int                   samples_sent = 0;
   int                   settings_used = 0;

   finite_difference_derivative_filter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_derivative   (rsp_derivative),
      .rsp_row          (rsp_row),
      .rsp_last_of_line (rsp_last_of_line)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 31);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_derivative(rsp_derivative, rsp_row, rsp_last_of_line);
   end

   function automatic bit take_gap();
      return !steady && ($urandom_range(0, 99) < 31);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.configure(idx, data);
   endtask

   task automatic set_config(logic [1:0] order, logic sec, logic [12:0] len,
                             logic [31:0] scl);
      write_reg(CSR_ORDER_MODE, {30'd0, order});
      write_reg(CSR_SECOND_DERIVATIVE, {31'd0, sec});
      write_reg(CSR_LINE_LENGTH, {19'd0, len});
      write_reg(CSR_SCALE, scl);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic send_sample(logic [15:0] v);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (!req_ready);
      tracker.note_sample(v);
      samples_sent++;
   endtask

   // always waits for the clock before checking, so valid is never driven twice in a step
   task automatic wait_empty();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_derivs.size() != 0);
   endtask

   // line-start samples give no result, so let the pipeline settle too
   task automatic drain();
      wait_empty();
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample(int flavour);
      case (flavour)
         0: return 16'($urandom_range(0, 65535));
         1: return 16'(int'($urandom_range(0, 64)) - 32);
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               3: return 16'hFFFF;
               default: return 16'($urandom_range(0, 65535));
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 4))
         0, 1: return 32'd65536;
         2: return $urandom();
         3: return 32'($urandom_range(1, 4096));
         default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd364;
      endcase
   endfunction

   initial begin
      logic [15:0] extreme_vals[8];
      int          n, len, flavour, phase, random_sent;
      logic [12:0] len_code;

      tracker = new();
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_ORDER_MODE;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_sample       <= '0;
      extreme_vals = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                       16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short line, order code three, full scale: saturates both ways
      set_config(2'd3, 1'b1, 13'd5, 32'hFFFF_FFFF);
      foreach (extreme_vals[i]) send_sample(extreme_vals[i]);
      drain();
      // zero length clamps to the minimum, zero scale
      set_config(2'd0, 1'b0, 13'd0, 32'd0);
      for (int i = 0; i < 8; i++) send_sample(pick_sample(2));
      drain();
      // oversized length clamps to the maximum, then the line gets cut short
      set_config(2'd1, 1'b1, 13'h1FFF, 32'd65536);
      for (int i = 0; i < 10; i++) send_sample(pick_sample(i % 3));
      drain();

      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         steady = (phase == 0);
         case ($urandom_range(0, 19))
            0, 1, 2: len_code = 13'($urandom_range(0, 7));
            3, 4:    len_code = 13'($urandom_range(21, 64));
            default: len_code = 13'($urandom_range(8, 20));
         endcase
         set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), len_code,
                    pick_scale());
         len     = tracker.eff_len();
         flavour = $urandom_range(0, 2);
         // mostly whole lines, sometimes a line broken off part way
         if ($urandom_range(0, 3) != 0) n = len * $urandom_range(1, 2) - tracker.position;
         else n = $urandom_range(1, 2 * len);
         if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
         for (int i = 0; i < n; i++) begin
            send_sample(pick_sample(flavour));
            random_sent++;
            if (i == n / 2 && (phase == 1 || $urandom_range(0, 5) == 0))
               wait_empty();
         end
         drain();
         phase++;
      end

      // one more whole line at full rate
      steady = 1'b1;
      set_config(2'd2, 1'b0, 13'd12, 32'd65536);
      for (int i = 0; i < 12; i++) send_sample(pick_sample(0));
      drain();
      steady = 1'b0;

      $display("covered %0d samples over %0d register settings", samples_sent,
               settings_used);
      $display("checked %0d derivative transfers, %0d mismatches", tracker.checked,
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_derivs.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[finite_difference_derivative_filter_unit.f]
sv/fddf_pkg.sv
sv/finite_difference_derivative_filter_unit.sv
sim/tb_top.sv
